// File: rtl/iad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_pkg - shared types and constants of the ima adpcm stream decoder
// Step table, index adjust table, header phase codes and the step record
// passed from the decode core to the top level.
// ----------------------------------------------------------------------------
package iad_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STEP_W   = 15;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned NIB_W    = 4;

  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // header progress of the current stream
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LO   = 2'd1,
    PH_HI   = 2'd2,
    PH_DATA = 2'd3
  } phase_e;

  // what the core does in one cycle
  typedef struct packed {
    logic                       emit;
    logic                       consume;
    logic                       last;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       hi_pend;
    logic                       cnt_zero;
  } iad_step_t;

  // standard ima step sizes
  localparam logic [STEP_W-1:0] STEP_TAB [89] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // step index adjust by nibble magnitude
  localparam logic signed [4:0] IDX_ADJ [8] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

endpackage

// File: rtl/ima_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_byte_if - compressed byte channel
// Valid/ready channel carrying one stream byte and its start marker per beat.
// ----------------------------------------------------------------------------
interface ima_byte_if
  import iad_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

// File: rtl/ima_pcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_pcm_if - decoded sample channel
// Valid/ready channel carrying one pcm sample and its last flag per beat.
// ----------------------------------------------------------------------------
interface ima_pcm_if
  import iad_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: rtl/iad_nib_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_nib_dec - one ima adpcm nibble update
// Step lookup, difference build, saturating predictor add and index clamp.
// ----------------------------------------------------------------------------
module iad_nib_dec
  import iad_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] pred_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [NIB_W-1:0]           nib_i,
  output logic signed [SAMPLE_W-1:0] pred_o,
  output logic [IDX_W-1:0]           idx_o
);

  logic [STEP_W-1:0]          step;
  logic [SAMPLE_W-1:0]        diff;
  logic signed [SAMPLE_W+1:0] pred_ext;
  logic signed [SAMPLE_W+1:0] diff_ext;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [IDX_W:0]      idx_sum;

  // difference from the step size and magnitude bits
  always_comb begin
    step = STEP_TAB[idx_i];
    diff = SAMPLE_W'(step >> 3);
    if (nib_i[0]) begin
      diff = diff + SAMPLE_W'(step >> 2);
    end
    if (nib_i[1]) begin
      diff = diff + SAMPLE_W'(step >> 1);
    end
    if (nib_i[2]) begin
      diff = diff + SAMPLE_W'(step);
    end
  end

  // predictor update with 16-bit saturation
  always_comb begin
    pred_ext = $signed({{2{pred_i[SAMPLE_W-1]}}, pred_i});
    diff_ext = $signed({2'b00, diff});
    sum      = nib_i[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);
    if (sum > (SAMPLE_W+2)'(SAMPLE_MAX)) begin
      pred_o = SAMPLE_MAX;
    end else if (sum < (SAMPLE_W+2)'(SAMPLE_MIN)) begin
      pred_o = SAMPLE_MIN;
    end else begin
      pred_o = sum[SAMPLE_W-1:0];
    end
  end

  // step index update clamped to the table
  always_comb begin
    idx_sum = $signed({1'b0, idx_i}) + (IDX_W+1)'(IDX_ADJ[nib_i[2:0]]);
    if (idx_sum < 0) begin
      idx_o = '0;
    end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
      idx_o = IDX_MAX;
    end else begin
      idx_o = idx_sum[IDX_W-1:0];
    end
  end

endmodule

// File: rtl/iad_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_core - stream state and per-cycle step of the decoder
// Holds predictor, step index, header phase, sample count and nibble select;
// handles one header byte or one data nibble per enabled cycle.
// ----------------------------------------------------------------------------
module iad_core
  import iad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [BYTE_W-1:0]     byte_i,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] total_i,
  output iad_step_t             step_o
);

  logic signed [SAMPLE_W-1:0] pred_q, pred_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  phase_e                     phase_q, phase_d;
  logic [COUNT_BITS-1:0]      remain_q, remain_d;
  logic                       hi_sel_q, hi_sel_d;

  logic [NIB_W-1:0]           nib;
  logic signed [SAMPLE_W-1:0] dec_pred;
  logic [IDX_W-1:0]           dec_idx;
  logic [COUNT_BITS-1:0]      total_dec;
  logic [COUNT_BITS-1:0]      remain_dec;

  assign nib        = hi_sel_q ? byte_i[7:4] : byte_i[3:0];
  assign total_dec  = total_i - COUNT_BITS'(1);
  assign remain_dec = remain_q - COUNT_BITS'(1);

  iad_nib_dec u_nib_dec (
    .pred_i (pred_q),
    .idx_i  (idx_q),
    .nib_i  (nib),
    .pred_o (dec_pred),
    .idx_o  (dec_idx)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q   <= '0;
      idx_q    <= '0;
      phase_q  <= PH_IDLE;
      remain_q <= '0;
      hi_sel_q <= 1'b0;
    end else begin
      pred_q   <= pred_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      remain_q <= remain_d;
      hi_sel_q <= hi_sel_d;
    end
  end

  // one header byte or one nibble per enabled cycle
  always_comb begin
    pred_d   = pred_q;
    idx_d    = idx_q;
    phase_d  = phase_q;
    remain_d = remain_q;
    hi_sel_d = hi_sel_q;
    step_o          = '0;
    step_o.sample   = pred_q;
    step_o.hi_pend  = hi_sel_q;
    step_o.cnt_zero = (remain_q == '0);
    if (en_i) begin
      if (start_i) begin
        pred_d         = $signed({{(SAMPLE_W-BYTE_W){1'b0}}, byte_i});
        remain_d       = '0;
        phase_d        = PH_LO;
        hi_sel_d       = 1'b0;
        step_o.consume = 1'b1;
      end else begin
        case (phase_q)
          PH_LO: begin
            pred_d         = $signed({byte_i, pred_q[BYTE_W-1:0]});
            phase_d        = PH_HI;
            step_o.consume = 1'b1;
          end
          PH_HI: begin
            idx_d          = (byte_i > BYTE_W'(IDX_MAX)) ? IDX_MAX : byte_i[IDX_W-1:0];
            phase_d        = PH_DATA;
            remain_d       = total_i;
            step_o.consume = 1'b1;
            if (total_i != '0) begin
              remain_d      = total_dec;
              step_o.emit   = 1'b1;
              step_o.sample = pred_q;
              step_o.last   = (total_dec == '0);
            end
          end
          PH_DATA: begin
            if (remain_q != '0) begin
              pred_d        = dec_pred;
              idx_d         = dec_idx;
              remain_d      = remain_dec;
              step_o.emit   = 1'b1;
              step_o.sample = dec_pred;
              step_o.last   = (remain_dec == '0);
              if (!hi_sel_q && (remain_dec != '0)) begin
                hi_sel_d = 1'b1;
              end else begin
                hi_sel_d       = 1'b0;
                step_o.consume = 1'b1;
              end
            end else begin
              hi_sel_d       = 1'b0;
              step_o.consume = 1'b1;
            end
          end
          default: begin
            // idle: byte without a stream start is dropped
            step_o.consume = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/ima_adpcm_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_stream_decoder - streaming 4-bit ima adpcm decoder
// Three header bytes set the predictor and step index, then every data byte
// yields its low and high nibble samples, up to a configured sample count.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  in_i      in   data_byte[7:0], stream_start     valid/ready
//  out_o     out  sample[15:0] signed, last        valid/ready
//  cfg       in   cfg_wdata_i[23:0] total_samples  cfg_we_i, no ready
//
//  a header byte is handled whole; a data byte a nibble at a time, low first,
//  by the single shared nibble decoder feeding the output register
//  a byte is held in the input register while its nibbles are decoded, and the
//  next byte is taken in the cycle its last nibble goes out
//  reset clears the stream state and the sample count register to zero
//  a stalled output holds the result register and, through it, the input side
// ----------------------------------------------------------------------------
module ima_adpcm_stream_decoder
  import iad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ima_byte_if.sink         in_i,
  ima_pcm_if.source        out_o
);

  logic [CFG_W-1:0]           total_q;
  logic [COUNT_BITS-1:0]      total_cnt;

  logic                       in_valid_q;
  logic [BYTE_W-1:0]          byte_q;
  logic                       start_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_last_q;

  logic                       out_free;
  logic                       step_en;
  iad_step_t                  step;

  assign total_cnt = COUNT_BITS'(total_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign step_en   = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step.consume;

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign out_o.last   = out_last_q;

  // sample count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step.consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.stream_start;
    end
  end

  iad_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (step_en),
    .byte_i  (byte_q),
    .start_i (start_q),
    .total_i (total_cnt),
    .step_o  (step)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.emit) begin
      out_sample_q <= step.sample;
      out_last_q   <= step.last;
    end
  end

  // a last sample on the output means the stream count is used up
  a_last_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> step.cnt_zero)
    else $error("last sample shown while samples remain");

  // a pending high nibble always has its byte in the input register
  a_hi_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.hi_pend |-> in_valid_q)
    else $error("high nibble pending without a held byte");

  // a new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.emit |-> out_free)
    else $error("result written into an occupied output register");

  // a high nibble is armed only by a decoded low nibble result
  a_hi_after_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(step.hi_pend) |-> $past(step.emit))
    else $error("high nibble armed without a low nibble result");

endmodule

// File: tb/tb_ima_adpcm_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ima_adpcm_stream_decoder - self-checking bench for the ima adpcm decoder
// Drives compressed bytes through the byte channel with random gaps and
// back-pressure, predicts each pcm sample and its last flag in a behavioral
// decoder in the bench or takes it from the directed table, and checks each
// output beat in order. Starts with a short table of header and end-of-stream
// cases, then random streams under several sample counts.
// ----------------------------------------------------------------------------
module tb_ima_adpcm_stream_decoder;
  import iad_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int HOLD_AFTER   = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_REPORTS  = 20;
  localparam int PREDICTED    = -1;
  localparam int LIMIT_NS     = 5_000_000;
  localparam int NUM_ROWS     = 31;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pcm_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_COUNT
  } row_kind_e;

  // one directed step: a byte beat or a sample count write
  typedef struct packed {
    row_kind_e                  kind;
    logic                       start;
    logic [CFG_W-1:0]           arg;
    int                         n_typed;
    logic signed [SAMPLE_W-1:0] s0;
    logic                       l0;
    logic signed [SAMPLE_W-1:0] s1;
    logic                       l1;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  ima_byte_if byte_ch ();
  ima_pcm_if  pcm_ch ();

  ima_adpcm_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (byte_ch),
    .out_o       (pcm_ch)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder shadow state
  int               est_pred;
  int               est_idx;
  phase_e           est_phase;
  logic [CFG_W-1:0] est_left;
  logic [CFG_W-1:0] count_cfg;
  pcm_t             pcm_due [$];

  int  errors;
  int  checked;
  int  bytes_sent;
  int  effective;
  int  streams_opened;
  int  count_writes;
  bit  steady;

  // one ima nibble against the shadow predictor and step index
  function automatic logic signed [SAMPLE_W-1:0] decode_nibble(logic [NIB_W-1:0] nib);
    int step;
    int diff;
    int acc;
    step = int'(STEP_TAB[est_idx]);
    diff = step >>> 3;
    if (nib[0]) diff += step >>> 2;
    if (nib[1]) diff += step >>> 1;
    if (nib[2]) diff += step;
    if (nib[3]) diff = -diff;
    acc = est_pred + diff;
    if (acc > int'(SAMPLE_MAX)) acc = int'(SAMPLE_MAX);
    if (acc < int'(SAMPLE_MIN)) acc = int'(SAMPLE_MIN);
    est_pred = acc;
    est_idx = est_idx + int'(IDX_ADJ[nib[2:0]]);
    if (est_idx < 0) est_idx = 0;
    if (est_idx > int'(IDX_MAX)) est_idx = int'(IDX_MAX);
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic void emit_sample(logic signed [SAMPLE_W-1:0] v, bit queue_it);
    pcm_t p;
    est_left = est_left - 1'b1;
    p.sample = v;
    p.last   = (est_left == '0);
    if (queue_it) pcm_due.push_back(p);
  endfunction

  // advance the shadow decoder by one byte; returns 0 when the byte is ignored
  function automatic bit decode_byte(logic [BYTE_W-1:0] b, logic s, bit queue_it);
    logic [SAMPLE_W-1:0] word;
    if (s) begin
      est_pred = int'(b);
      est_left = '0;
      est_phase = PH_LO;
      streams_opened++;
      return 1'b1;
    end
    case (est_phase)
      PH_LO: begin
        word = {b, est_pred[7:0]};
        est_pred = int'($signed(word));
        est_phase = PH_HI;
        return 1'b1;
      end
      PH_HI: begin
        est_idx = (b > IDX_MAX) ? int'(IDX_MAX) : int'(b);
        est_phase = PH_DATA;
        est_left = count_cfg;
        if (est_left != '0) emit_sample(est_pred[SAMPLE_W-1:0], queue_it);
        return 1'b1;
      end
      PH_DATA: begin
        if (est_left == '0) return 1'b0;
        emit_sample(decode_nibble(b[3:0]), queue_it);
        if (est_left != '0) emit_sample(decode_nibble(b[7:4]), queue_it);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(string what, int want_v, int got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // offer one byte beat, with random gaps unless steady, then predict once it is taken
  task automatic send_byte(logic [BYTE_W-1:0] b, logic s, bit queue_it);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= b;
    byte_ch.stream_start <= s;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
    if (decode_byte(b, s, queue_it)) effective++;
  endtask

  // let the block finish all outstanding work before touching the count
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pcm_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    count_cfg = v;
    count_writes++;
  endtask

  // one random stream: mostly well formed, some noise and cut-off headers
  task automatic send_stream(logic [CFG_W-1:0] cnt);
    int               kind;
    int               n_data;
    logic [15:0]      init_pred;
    logic [BYTE_W-1:0] idx_byte;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 4))
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else if (kind == 1) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      if ($urandom_range(0, 1) == 1)
        send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      if ($urandom_range(0, 9) == 0)
        init_pred = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
      else
        init_pred = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0)
        idx_byte = BYTE_W'($urandom_range(89, 255));
      else
        idx_byte = BYTE_W'($urandom_range(0, 88));
      if (cnt <= 40)
        n_data = int'($urandom_range(0, cnt / 2 + 3));
      else if ($urandom_range(0, 14) == 0)
        n_data = 300;
      else
        n_data = int'($urandom_range(1, 40));
      send_byte(init_pred[7:0], 1'b1, 1'b1);
      send_byte(init_pred[15:8], 1'b0, 1'b1);
      send_byte(idx_byte, 1'b0, 1'b1);
      repeat (n_data) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // directed cases: idle byte, extremes, count ending mid-byte, restart, zero count
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_COUNT, 1'b0, 24'd4,     0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h37,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b1, 24'h00,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h80,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h00,    1,         SAMPLE_MIN, 1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'hff,    2,         SAMPLE_MIN, 1'b0, SAMPLE_MIN, 1'b0},
    '{ROW_BYTE,  1'b0, 24'h12,    PREDICTED, 16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h55,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b1, 24'hff,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h7f,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'hc8,    1,         SAMPLE_MAX, 1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h77,    2,         SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0},
    '{ROW_BYTE,  1'b1, 24'h34,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h12,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h59,    1,         16'sh1234,  1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h08,    PREDICTED, 16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h80,    PREDICTED, 16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_COUNT, 1'b0, 24'd0,     0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b1, 24'h11,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h22,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h05,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'hab,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_COUNT, 1'b0, 24'd1,     0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b1, 24'h00,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h00,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h00,    1,         16'sd0,     1'b1, 16'sd0,     1'b0},
    '{ROW_COUNT, 1'b0, 24'hffffff, 0,        16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b1, 24'ha5,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h5a,    0,         16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h2c,    PREDICTED, 16'sd0,     1'b0, 16'sd0,     1'b0},
    '{ROW_BYTE,  1'b0, 24'h9e,    PREDICTED, 16'sd0,     1'b0, 16'sd0,     1'b0}
  };

  // sample receiver: random stalls, one long hold-off, a stall-free stretch
  initial begin
    int taken;
    int hold_left;
    bit held;
    taken = 0;
    hold_left = 0;
    held = 1'b0;
    pcm_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pcm_ch.valid && pcm_ch.ready) taken++;
      if (hold_left != 0) begin
        hold_left--;
        pcm_ch.ready <= 1'b0;
      end else if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        pcm_ch.ready <= 1'b0;
      end else if (steady) begin
        pcm_ch.ready <= 1'b1;
      end else begin
        pcm_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each sample beat with the oldest prediction
  always @(posedge clk_i) begin
    pcm_t want;
    if (rst_ni && pcm_ch.valid && pcm_ch.ready) begin
      checked++;
      if (pcm_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: sample %0d last %0b arrived with nothing expected",
                   $time, pcm_ch.sample, pcm_ch.last);
      end else begin
        want = pcm_due.pop_front();
        if (pcm_ch.sample !== want.sample)
          note_mismatch("sample", int'(want.sample), int'(pcm_ch.sample));
        if (pcm_ch.last !== want.last)
          note_mismatch("last", int'(want.last), int'(pcm_ch.last));
      end
    end
  end

  // stimulus
  initial begin
    logic [CFG_W-1:0] cnt;
    pcm_t             typed;
    int               phase_base;
    errors = 0;
    checked = 0;
    bytes_sent = 0;
    effective = 0;
    streams_opened = 0;
    count_writes = 0;
    steady = 1'b0;
    est_pred = 0;
    est_idx = 0;
    est_phase = PH_IDLE;
    est_left = '0;
    count_cfg = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.stream_start = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_COUNT) begin
        drain();
        set_count(directed_rows[r].arg);
      end else begin
        send_byte(directed_rows[r].arg[BYTE_W-1:0], directed_rows[r].start,
                  directed_rows[r].n_typed == PREDICTED);
        if (directed_rows[r].n_typed >= 1) begin
          typed.sample = directed_rows[r].s0;
          typed.last   = directed_rows[r].l0;
          pcm_due.push_back(typed);
        end
        if (directed_rows[r].n_typed >= 2) begin
          typed.sample = directed_rows[r].s1;
          typed.last   = directed_rows[r].l1;
          pcm_due.push_back(typed);
        end
      end
    end

    // random streams, one sample count per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       cnt = 24'd3;
        1:       cnt = 24'd1;
        3:       cnt = 24'd0;
        4:       cnt = 24'd2;
        5:       cnt = CFG_W'($urandom_range(41, 400));
        6:       cnt = 24'hffffff;
        8:       cnt = CFG_W'($urandom_range(401, 5000));
        default: cnt = CFG_W'($urandom_range(4, 40));
      endcase
      drain();
      steady = (ph == 5);
      set_count(cnt);
      phase_base = effective;
      while (effective - phase_base < PHASE_ITEMS) send_stream(cnt);
    end
    steady = 1'b0;

    // wind down
    byte_ch.valid <= 1'b0;
    while (pcm_due.size() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d bytes (%0d decoded), %0d streams, %0d samples checked",
             bytes_sent, effective, streams_opened, checked);
    $display("run: %0d sample count settings incl. zero, one and full scale",
             count_writes);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("%0t ns: timeout with %0d samples outstanding", $time, pcm_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
